// File: rtl/sawq_pkg.sv
// Shared types and constants of the slot allocator with wait queue.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
`default_nettype none
package sawq_pkg;

	localparam int FUNC_W     = 2;
	localparam int REQ_ID_W   = 8;
	localparam int SLOT_IDX_W = 4;
	localparam int STATUS_W   = 4;
	localparam int SLOT_NUM_W = 4;
	localparam int OWNER_W    = 8;
	localparam int QLEN_W     = 5;
	localparam int ACTIVE_W   = 5;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ARRIVE      = 2'd0,
		FUNC_RELEASE     = 2'd1,
		FUNC_LIST_QUEUE  = 2'd2,
		FUNC_LIST_SLOTS  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED        = 4'd0,
		ST_QUEUED        = 4'd1,
		ST_DROPPED       = 4'd2,
		ST_FREED         = 4'd3,
		ST_REFILLED      = 4'd4,
		ST_WAS_FREE      = 4'd5,
		ST_BAD_INDEX     = 4'd6,
		ST_QUEUE_HEADER  = 4'd7,
		ST_QUEUE_ENTRY   = 4'd8,
		ST_SLOT_ENTRY    = 4'd9,
		ST_NONE_OCCUPIED = 4'd10
	} status_t;

	typedef struct packed {
		func_t                 func;
		logic [REQ_ID_W-1:0]   requester_id;
		logic [SLOT_IDX_W-1:0] slot_index;
	} req_item_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_NUM_W-1:0] slot_number;
		logic [OWNER_W-1:0]    owner_id;
		logic [QLEN_W-1:0]     queue_length;
		logic                  last;
	} rsp_item_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic rd_decode;
		logic exec_op;
		logic ld_header;
		logic ld_none;
		logic lq_rd;
		logic lq_ld;
		logic ls_rd;
		logic ls_ld;
		logic idx_clr;
		logic idx_inc;
	} ctrl_t;

	// status from the datapath to the controller
	typedef struct packed {
		func_t func;
		logic  out_free;
		logic  queue_empty;
		logic  any_busy;
		logic  busy_at_idx;
		logic  lq_last;
		logic  ls_last;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/sawq_ctrl.sv
// Sequencing state machine of the slot allocator.
// Depends on sawq_pkg for the command and status structs.
`default_nettype none
module sawq_ctrl
	import sawq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_ready,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_DECODE  = 7'b0000010,
		S_EXEC    = 7'b0000100,
		S_LQ_RD   = 7'b0001000,
		S_LQ_OUT  = 7'b0010000,
		S_LS_SCAN = 7'b0100000,
		S_LS_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_n;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		ctrl    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctrl.capture = 1'b1;
					state_n      = S_DECODE;
				end
			end
			S_DECODE: begin
				ctrl.rd_decode = 1'b1;
				state_n        = S_EXEC;
			end
			S_EXEC: begin
				unique case (stat.func)
					FUNC_ARRIVE, FUNC_RELEASE: begin
						if (stat.out_free) begin
							ctrl.exec_op = 1'b1;
							state_n      = S_IDLE;
						end
					end
					FUNC_LIST_QUEUE: begin
						if (stat.out_free) begin
							ctrl.ld_header = 1'b1;
							if (stat.queue_empty) begin
								state_n = S_IDLE;
							end else begin
								ctrl.idx_clr = 1'b1;
								state_n      = S_LQ_RD;
							end
						end
					end
					FUNC_LIST_SLOTS: begin
						if (!stat.any_busy) begin
							if (stat.out_free) begin
								ctrl.ld_none = 1'b1;
								state_n      = S_IDLE;
							end
						end else begin
							ctrl.idx_clr = 1'b1;
							state_n      = S_LS_SCAN;
						end
					end
					default: state_n = S_IDLE;
				endcase
			end
			S_LQ_RD: begin
				ctrl.lq_rd = 1'b1;
				state_n    = S_LQ_OUT;
			end
			S_LQ_OUT: begin
				if (stat.out_free) begin
					ctrl.lq_ld = 1'b1;
					if (stat.lq_last) begin
						state_n = S_IDLE;
					end else begin
						ctrl.idx_inc = 1'b1;
						state_n      = S_LQ_RD;
					end
				end
			end
			S_LS_SCAN: begin
				// skip free slots, read the owner of a busy one
				if (stat.busy_at_idx) begin
					ctrl.ls_rd = 1'b1;
					state_n    = S_LS_OUT;
				end else begin
					ctrl.idx_inc = 1'b1;
				end
			end
			S_LS_OUT: begin
				if (stat.out_free) begin
					ctrl.ls_ld = 1'b1;
					if (stat.ls_last) begin
						state_n = S_IDLE;
					end else begin
						ctrl.idx_inc = 1'b1;
						state_n      = S_LS_SCAN;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule
`default_nettype wire

// File: rtl/sawq_dpath.sv
// Datapath of the slot allocator: slot state, owner and queue memories,
// free/busy encoders, scan counter and output register. Depends on sawq_pkg.
`default_nettype none
module sawq_dpath
	import sawq_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [ACTIVE_W-1:0] cfg_wr_data,
	input  wire req_item_t           req,
	output rsp_item_t                rsp,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	input  wire ctrl_t               ctrl,
	output stat_t                    stat
);

	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW  = $clog2(SLOTS + 1);
	localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int IW  = (SIW > QW) ? SIW : QW;

	localparam logic [QW:0]   QD_W    = (QW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] QD_CNT  = CW'(QUEUE_DEPTH);

	// control state
	logic [ACTIVE_W-1:0] active_q;
	logic [SLOTS-1:0]    busy_q;
	logic [QW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       idx_q;
	logic                rsp_valid_q;

	// payload
	req_item_t           cmd_q;
	rsp_item_t           rsp_q;
	logic [SIW-1:0]      lf_q, hb_q;
	logic                lf_found_q, hb_found_q;

	logic [ID_BITS-1:0]  owner_mem [SLOTS];
	logic [ID_BITS-1:0]  fifo_mem  [QUEUE_DEPTH];
	logic [ID_BITS-1:0]  own_rd_q, fifo_rd_q;

	function automatic logic [QW-1:0] wrap(input logic [QW-1:0] base, input logic [QW:0] off);
		logic [QW:0] sum;
		sum = {1'b0, base} + off;
		if (sum >= QD_W) begin
			sum = sum - QD_W;
		end
		return sum[QW-1:0];
	endfunction

	// active slot count, clamped
	logic [NW-1:0]    n_act;
	logic [SLOTS-1:0] act_mask;
	logic [SIW-1:0]   idx_s;
	logic [SIW-1:0]   scan_s;

	always_comb begin
		if (active_q == '0) begin
			n_act = NW'(1);
		end else if (int'(active_q) > SLOTS) begin
			n_act = NW'(SLOTS);
		end else begin
			n_act = NW'(active_q);
		end
		for (int k = 0; k < SLOTS; k++) begin
			act_mask[k] = (k < int'(n_act));
		end
	end

	assign idx_s  = SIW'(cmd_q.slot_index);
	assign scan_s = idx_q[SIW-1:0];

	// lowest free and highest busy slot, registered
	logic [SIW-1:0] lf_n, hb_n;
	logic           lf_found_n, hb_found_n;

	always_comb begin
		lf_n       = '0;
		lf_found_n = 1'b0;
		hb_n       = '0;
		hb_found_n = 1'b0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (act_mask[k] && !busy_q[k]) begin
				lf_n       = SIW'(k);
				lf_found_n = 1'b1;
			end
		end
		for (int k = 0; k < SLOTS; k++) begin
			if (act_mask[k] && busy_q[k]) begin
				hb_n       = SIW'(k);
				hb_found_n = 1'b1;
			end
		end
	end

	// execution of arrive and release
	logic               bad_idx;
	logic [SIW-1:0]     refill_s;
	logic               busy_set, busy_clr;
	logic [SIW-1:0]     set_s;
	logic               own_we, fifo_we, head_inc, cnt_inc, cnt_dec;
	logic [ID_BITS-1:0] own_wd;
	logic [ID_BITS-1:0] id_w;
	rsp_item_t          ex_rsp;
	logic [SLOTS-1:0]   busy_n;

	assign id_w     = ID_BITS'(cmd_q.requester_id);
	assign bad_idx  = (int'(cmd_q.slot_index) >= int'(n_act));
	assign refill_s = (lf_found_q && (lf_q < idx_s)) ? lf_q : idx_s;

	always_comb begin
		busy_set = 1'b0;
		busy_clr = 1'b0;
		set_s    = lf_q;
		own_we   = 1'b0;
		own_wd   = id_w;
		fifo_we  = 1'b0;
		head_inc = 1'b0;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		ex_rsp.status       = ST_PLACED;
		ex_rsp.slot_number  = '0;
		ex_rsp.owner_id     = OWNER_W'(id_w);
		ex_rsp.queue_length = QLEN_W'(count_q);
		ex_rsp.last         = 1'b1;
		if (cmd_q.func == FUNC_ARRIVE) begin
			priority if (lf_found_q) begin
				busy_set           = 1'b1;
				own_we             = 1'b1;
				ex_rsp.slot_number = SLOT_NUM_W'(lf_q);
			end else if (count_q != QD_CNT) begin
				fifo_we             = 1'b1;
				cnt_inc             = 1'b1;
				ex_rsp.status       = ST_QUEUED;
				ex_rsp.queue_length = QLEN_W'(count_q + CW'(1));
			end else begin
				ex_rsp.status = ST_DROPPED;
			end
		end else begin
			ex_rsp.slot_number = SLOT_NUM_W'(cmd_q.slot_index);
			ex_rsp.owner_id    = '0;
			priority if (bad_idx) begin
				ex_rsp.status = ST_BAD_INDEX;
			end else if (!busy_q[idx_s]) begin
				ex_rsp.status = ST_WAS_FREE;
			end else if (count_q == '0) begin
				busy_clr        = 1'b1;
				ex_rsp.status   = ST_FREED;
				ex_rsp.owner_id = OWNER_W'(own_rd_q);
			end else begin
				// hand the lowest free slot to the queue head
				busy_clr            = 1'b1;
				busy_set            = 1'b1;
				set_s               = refill_s;
				own_we              = 1'b1;
				own_wd              = fifo_rd_q;
				head_inc            = 1'b1;
				cnt_dec             = 1'b1;
				ex_rsp.status       = ST_REFILLED;
				ex_rsp.slot_number  = SLOT_NUM_W'(refill_s);
				ex_rsp.owner_id     = OWNER_W'(fifo_rd_q);
				ex_rsp.queue_length = QLEN_W'(count_q - CW'(1));
			end
		end
	end

	// next busy map: clear the released slot, then set the placed one
	always_comb begin
		busy_n = busy_q;
		if (busy_clr) begin
			busy_n[idx_s] = 1'b0;
		end
		if (busy_set) begin
			busy_n[set_s] = 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			busy_q   <= '0;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (ctrl.exec_op) begin
				busy_q <= busy_n;
				if (head_inc) begin
					head_q <= wrap(head_q, (QW + 1)'(1));
				end
				if (cnt_inc) begin
					count_q <= count_q + CW'(1);
				end else if (cnt_dec) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (ctrl.idx_clr) begin
				idx_q <= '0;
			end else if (ctrl.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= req;
		end
		lf_q       <= lf_n;
		lf_found_q <= lf_found_n;
		hb_q       <= hb_n;
		hb_found_q <= hb_found_n;
	end

	// owner memory
	always_ff @(posedge clk) begin
		if (ctrl.exec_op && own_we) begin
			owner_mem[set_s] <= own_wd;
		end
		if (ctrl.rd_decode) begin
			own_rd_q <= owner_mem[idx_s];
		end else if (ctrl.ls_rd) begin
			own_rd_q <= owner_mem[scan_s];
		end
	end

	// wait queue memory
	always_ff @(posedge clk) begin
		if (ctrl.exec_op && fifo_we) begin
			fifo_mem[wrap(head_q, (QW + 1)'(count_q))] <= id_w;
		end
		if (ctrl.rd_decode) begin
			fifo_rd_q <= fifo_mem[head_q];
		end else if (ctrl.lq_rd) begin
			fifo_rd_q <= fifo_mem[wrap(head_q, (QW + 1)'(idx_q))];
		end
	end

	// output register
	logic      rsp_ld;
	rsp_item_t rsp_n;

	assign rsp_ld = ctrl.exec_op | ctrl.ld_header | ctrl.ld_none | ctrl.lq_ld | ctrl.ls_ld;

	always_comb begin
		rsp_n = ex_rsp;
		if (ctrl.ld_header) begin
			rsp_n.status       = ST_QUEUE_HEADER;
			rsp_n.slot_number  = '0;
			rsp_n.owner_id     = '0;
			rsp_n.queue_length = QLEN_W'(count_q);
			rsp_n.last         = (count_q == '0);
		end else if (ctrl.ld_none) begin
			rsp_n.status       = ST_NONE_OCCUPIED;
			rsp_n.slot_number  = '0;
			rsp_n.owner_id     = '0;
			rsp_n.queue_length = QLEN_W'(count_q);
			rsp_n.last         = 1'b1;
		end else if (ctrl.lq_ld) begin
			rsp_n.status       = ST_QUEUE_ENTRY;
			rsp_n.slot_number  = SLOT_NUM_W'(idx_q);
			rsp_n.owner_id     = OWNER_W'(fifo_rd_q);
			rsp_n.queue_length = QLEN_W'(count_q);
			rsp_n.last         = stat.lq_last;
		end else if (ctrl.ls_ld) begin
			rsp_n.status       = ST_SLOT_ENTRY;
			rsp_n.slot_number  = SLOT_NUM_W'(idx_q);
			rsp_n.owner_id     = OWNER_W'(own_rd_q);
			rsp_n.queue_length = QLEN_W'(count_q);
			rsp_n.last         = stat.ls_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ld) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign stat.func        = cmd_q.func;
	assign stat.out_free    = !rsp_valid_q || rsp_ready;
	assign stat.queue_empty = (count_q == '0);
	assign stat.any_busy    = hb_found_q;
	assign stat.busy_at_idx = busy_q[scan_s];
	assign stat.lq_last     = ((int'(idx_q) + 1) == int'(count_q));
	assign stat.ls_last     = (scan_s == hb_q);

endmodule
`default_nettype wire

// File: rtl/slot_allocator_with_wait_queue.sv
// Top level of the slot allocator with wait queue.
// Depends on sawq_pkg, sawq_ctrl and sawq_dpath.
//
// Usage:
//   req / req_valid / req_ready carry one command item: arrive (take the lowest
//   free active slot, else join the wait queue, else drop), release (free a
//   slot; queue head gets lowest free slot), list queue, list occupied slots.
//   rsp / rsp_valid / rsp_ready carry result items; rsp.last closes the run
//   of results for one command. cfg_wr_en / cfg_wr_data write active_slots.
// Sequencing:
//   A command is taken in the idle state. Arrive and release pass through
//   decode (owner and queue memory reads) and execute, which loads their
//   single result; the next command is taken only after that. List queue
//   loads the header in execute, then each entry by a queue memory read
//   followed by an output load. List slots visits one slot per cycle and
//   adds an owner memory read step and an output load on each busy slot.
// Reset:
//   arst_n clears all slots to free, empties the queue and sets active_slots
//   to 16. Owner and queue memories are not cleared.
// Stall:
//   A result waits in the output register while rsp_ready is low; the
//   sequencer holds until the register can take the next result.
`default_nettype none
module slot_allocator_with_wait_queue
	import sawq_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [ACTIVE_W-1:0] cfg_wr_data,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire req_item_t           req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output rsp_item_t                rsp
);

	// command and status between sequencer and datapath
	ctrl_t ctrl;
	stat_t stat;

	sawq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// slot state, memories, encoders and output register
	sawq_dpath #(
		.SLOTS       (SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.ctrl        (ctrl),
		.stat        (stat)
	);

endmodule
`default_nettype wire

// File: rtl/sawq_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
// Depends on sawq_pkg and slot_allocator_with_wait_queue.
`default_nettype none
module sawq_checker
	import sawq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire rsp_item_t rsp
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// one command at a time: busy right after acceptance
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command accepted while busy");

	// single-result statuses always close their run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_PLACED || rsp.status == ST_QUEUED ||
		rsp.status == ST_DROPPED || rsp.status == ST_FREED ||
		rsp.status == ST_REFILLED || rsp.status == ST_WAS_FREE ||
		rsp.status == ST_BAD_INDEX || rsp.status == ST_NONE_OCCUPIED) |-> rsp.last)
		else $error("single result without last");

	// queue occupancy never exceeds its depth
	a_qlen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> int'(rsp.queue_length) <= QUEUE_DEPTH)
		else $error("queue length out of range");

	// queued or dropped arrivals report slot zero
	a_queued_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_QUEUED || rsp.status == ST_DROPPED)
		|-> rsp.slot_number == '0)
		else $error("queued item with nonzero slot");

endmodule

bind slot_allocator_with_wait_queue sawq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_sawq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for slot_allocator_with_wait_queue.
// Depends on sawq_pkg and the top level; drives commands, predicts each result
// with its own pool and wait queue, and checks every result field.
`timescale 1ns / 100ps
module tb;
	import sawq_pkg::*;

	localparam int POOL_SLOTS = 16;
	localparam int WAIT_DEPTH = 16;
	localparam int PHASES     = 8;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [ACTIVE_W-1:0] cfg_wr_data = '0;
	logic                req_valid   = 1'b0;
	logic                req_ready;
	req_item_t           req         = '0;
	logic                rsp_valid;
	logic                rsp_ready   = 1'b0;
	rsp_item_t           rsp;

	slot_allocator_with_wait_queue i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	always #4 clk = ~clk;

	// Commands waiting to be offered, and results owed by the block in order.
	req_item_t pending_cmds[$];
	rsp_item_t expected_rsps[$];

	// Shadow of the block: the slot pool, the wait queue and active_slots.
	bit               slot_taken[POOL_SLOTS];
	logic [7:0]       slot_holder[POOL_SLOTS];
	logic [7:0]       waitq[WAIT_DEPTH];
	int               wq_head    = 0;
	int               wq_count   = 0;
	logic [ACTIVE_W-1:0] active_cfg = ACTIVE_RESET;

	int  mismatches    = 0;
	int  accepted_cmds = 0;
	bit  req_fire      = 1'b0;
	int  req_gap       = 0;
	int  req_calm      = 0;
	int  rsp_gap       = 0;
	int  rsp_calm      = 0;
	int  hold_left     = 0;
	bit  held_off      = 1'b0;

	// Append a command to the pending list.
	function automatic void add_cmd(req_item_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Take the oldest pending command.
	function automatic req_item_t take_cmd();
		req_item_t c;
		c = pending_cmds[0];
		pending_cmds.delete(0);
		return c;
	endfunction

	// Clamp the register to the usable slot count: zero acts as one slot,
	// anything past the pool acts as the full pool.
	function automatic int eff_slots();
		if (active_cfg == 0) return 1;
		if (active_cfg > POOL_SLOTS) return POOL_SLOTS;
		return int'(active_cfg);
	endfunction

	function automatic int first_free(int n);
		for (int i = 0; i < n; i++)
			if (!slot_taken[i]) return i;
		return -1;
	endfunction

	// Queue one owed result; queue_length is the wait queue size after the step.
	function automatic void owe_rsp(status_t st, int slot, int owner, bit last);
		rsp_item_t r;
		r.status       = st;
		r.slot_number  = SLOT_NUM_W'(slot);
		r.owner_id     = OWNER_W'(owner);
		r.queue_length = QLEN_W'(wq_count);
		r.last         = last;
		expected_rsps.insert(expected_rsps.size(), r);
	endfunction

	// Advance the shadow state by one accepted command and owe its results.
	function automatic void apply_cmd(req_item_t c);
		int n;
		int s;
		int old_owner;
		int moved;
		int last_busy;
		n = eff_slots();
		case (c.func)
			FUNC_ARRIVE: begin
				s = first_free(n);
				if (s >= 0) begin
					slot_taken[s]  = 1'b1;
					slot_holder[s] = c.requester_id;
					owe_rsp(ST_PLACED, s, int'(c.requester_id), 1'b1);
				end else if (wq_count < WAIT_DEPTH) begin
					waitq[(wq_head + wq_count) % WAIT_DEPTH] = c.requester_id;
					wq_count++;
					owe_rsp(ST_QUEUED, 0, int'(c.requester_id), 1'b1);
				end else begin
					owe_rsp(ST_DROPPED, 0, int'(c.requester_id), 1'b1);
				end
			end
			FUNC_RELEASE: begin
				if (c.slot_index >= n) begin
					owe_rsp(ST_BAD_INDEX, int'(c.slot_index), 0, 1'b1);
				end else if (!slot_taken[c.slot_index]) begin
					owe_rsp(ST_WAS_FREE, int'(c.slot_index), 0, 1'b1);
				end else begin
					old_owner = int'(slot_holder[c.slot_index]);
					slot_taken[c.slot_index] = 1'b0;
					if (wq_count > 0) begin
						// hand the lowest free slot to the queue head
						moved   = int'(waitq[wq_head]);
						wq_head = (wq_head + 1) % WAIT_DEPTH;
						wq_count--;
						s = first_free(n);
						if (s < 0) s = int'(c.slot_index);
						slot_taken[s]  = 1'b1;
						slot_holder[s] = 8'(moved);
						owe_rsp(ST_REFILLED, s, moved, 1'b1);
					end else begin
						owe_rsp(ST_FREED, int'(c.slot_index), old_owner, 1'b1);
					end
				end
			end
			FUNC_LIST_QUEUE: begin
				owe_rsp(ST_QUEUE_HEADER, 0, 0, wq_count == 0);
				for (int i = 0; i < wq_count; i++)
					owe_rsp(ST_QUEUE_ENTRY, i, int'(waitq[(wq_head + i) % WAIT_DEPTH]),
						i + 1 == wq_count);
			end
			default: begin
				last_busy = -1;
				for (int i = 0; i < n; i++)
					if (slot_taken[i]) last_busy = i;
				if (last_busy < 0) begin
					owe_rsp(ST_NONE_OCCUPIED, 0, 0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						if (slot_taken[i])
							owe_rsp(ST_SLOT_ENTRY, i, int'(slot_holder[i]),
								i == last_busy);
				end
			end
		endcase
	endfunction

	function automatic req_item_t make_cmd(func_t f, int id, int idx);
		req_item_t c;
		c.func         = f;
		c.requester_id = REQ_ID_W'(id);
		c.slot_index   = SLOT_IDX_W'(idx);
		return c;
	endfunction

	// Draw one random command. Unused fields stay random so every input bit
	// toggles; releases mostly aim inside the active range.
	function automatic req_item_t random_cmd(int arrive_pct);
		req_item_t c;
		int r;
		r = $urandom_range(0, 99);
		c.requester_id = REQ_ID_W'($urandom_range(0, 255));
		c.slot_index   = SLOT_IDX_W'($urandom_range(0, 15));
		if (r < arrive_pct) begin
			c.func = FUNC_ARRIVE;
		end else if (r < arrive_pct + (100 - arrive_pct) * 7 / 10) begin
			c.func = FUNC_RELEASE;
			if ($urandom_range(0, 3) != 0)
				c.slot_index = SLOT_IDX_W'($urandom_range(0, eff_slots() - 1));
		end else if (r[0]) begin
			c.func = FUNC_LIST_QUEUE;
		end else begin
			c.func = FUNC_LIST_SLOTS;
		end
		return c;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Hold until every command is taken and every owed result has come back,
	// then let the pipeline settle.
	task automatic drain();
		while (pending_cmds.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_active(int v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ACTIVE_W'(v);
		active_cfg   = ACTIVE_W'(v);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Command driver: load the next item once the current one is taken, and
	// drop valid for the drawn gap in between. Calm stretches skip the gaps.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fire)) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				req       <= take_cmd();
				req_valid <= 1'b1;
				req_gap    = (req_calm > 0) ? 0 : draw_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
		if (req_calm > 0) req_calm--;
		else if ($urandom_range(0, 63) == 0) req_calm = $urandom_range(30, 90);
	end

	// Result receiver: random stalls, plus one long hold-off while the
	// sender still has plenty queued, so the block backs up into its input.
	always @(negedge clk) begin
		if (!held_off && accepted_cmds >= 30 && pending_cmds.size() >= 10) begin
			held_off  = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			rsp_gap    = (rsp_calm > 0) ? 0 : draw_gap();
		end
		if (rsp_calm > 0) rsp_calm--;
		else if ($urandom_range(0, 63) == 0) rsp_calm = $urandom_range(30, 90);
	end

	// Monitor: predict on every accepted command, check every accepted result
	// against the oldest owed one.
	always @(posedge clk) begin : monitor
		rsp_item_t want;
		if (arst_n) begin
			req_fire <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				apply_cmd(req);
				accepted_cmds++;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("result with nothing owed: status %0d slot %0d owner %0d",
						rsp.status, rsp.slot_number, rsp.owner_id);
					mismatches++;
				end else begin
					want = expected_rsps[0];
					expected_rsps.delete(0);
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("slot_number", 32'(want.slot_number),
						32'(rsp.slot_number));
					check_field("owner_id", 32'(want.owner_id), 32'(rsp.owner_id));
					check_field("queue_length", 32'(want.queue_length),
						32'(rsp.queue_length));
					check_field("last", 32'(want.last), 32'(rsp.last));
				end
			end
		end
	end

	// Random phases: register value, command count and arrive share. The
	// values cover zero acting as one slot, all ones acting as the full
	// pool, and a shrink and regrow that hides and reveals busy slots.
	int phase_cfg[PHASES]    = '{0, 31, 3, 16, 20, 8, 2, 16};
	int phase_len[PHASES]    = '{35, 45, 35, 40, 30, 35, 30, 40};
	int phase_arrive[PHASES] = '{55, 75, 50, 50, 40, 60, 45, 35};

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset setting of 16 slots: empty reports, release of a free slot,
		// placement at both ID extremes, a plain free.
		add_cmd(make_cmd(FUNC_LIST_SLOTS, 8'h3C, 4'd9));
		add_cmd(make_cmd(FUNC_LIST_QUEUE, 8'hC3, 4'd6));
		add_cmd(make_cmd(FUNC_RELEASE, 8'h5A, 4'd5));
		add_cmd(make_cmd(FUNC_ARRIVE, 8'h00, 4'd0));
		add_cmd(make_cmd(FUNC_ARRIVE, 8'hFF, 4'd15));
		add_cmd(make_cmd(FUNC_RELEASE, 8'hA5, 4'd0));
		drain();

		// One active slot: slot 1 stays busy but hidden. Fill slot 0, fill
		// the wait queue, drop one, list both sides, release out of range,
		// then free slot 0 so the queue head moves in.
		write_active(1);
		add_cmd(make_cmd(FUNC_ARRIVE, 8'h81, 4'd3));
		for (int i = 0; i < WAIT_DEPTH; i++)
			add_cmd(make_cmd(FUNC_ARRIVE, 8'h10 * i + i, i));
		add_cmd(make_cmd(FUNC_ARRIVE, 8'hA5, 4'd12));
		add_cmd(make_cmd(FUNC_LIST_QUEUE, 8'h00, 4'd0));
		add_cmd(make_cmd(FUNC_LIST_SLOTS, 8'hFF, 4'd15));
		add_cmd(make_cmd(FUNC_RELEASE, 8'h00, 4'd1));
		add_cmd(make_cmd(FUNC_RELEASE, 8'hFF, 4'd0));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_active(phase_cfg[p]);
			for (int i = 0; i < phase_len[p]; i++)
				add_cmd(random_cmd(phase_arrive[p]));
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#15_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
